@@ hw/rtl/rrspn_pkg.sv @@
// Package for the reduced-round SPN block cipher: widths, round count,
// S-box table, round constants and GF(2^8) helpers. No dependencies.
`timescale 1ns / 1ps
package rrspn_pkg;
	localparam int NumRounds = 4;

	typedef logic [7:0] byte_t;
	typedef logic [127:0] block_t;

	// Multiply by x modulo 0x11B
	function automatic byte_t xtime(input byte_t a);
		xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
	endfunction

	// Full GF(2^8) multiply, eight shift-and-add steps on narrow values
	function automatic byte_t gmul(input byte_t a, input byte_t b);
		byte_t acc;
		byte_t p;
		acc = 8'h00;
		p = a;
		for (int k = 0; k < 8; k++) begin
			if (b[k]) acc = acc ^ p;
			p = xtime(p);
		end
		gmul = acc;
	endfunction

	// Build the x^23 ^ 0x63 S-box as a constant table
	function automatic byte_t sbox_calc(input byte_t x);
		byte_t x2;
		byte_t x4;
		byte_t x8;
		byte_t x16;
		byte_t r;
		x2 = gmul(x, x);
		x4 = gmul(x2, x2);
		x8 = gmul(x4, x4);
		x16 = gmul(x8, x8);
		r = gmul(gmul(gmul(x, x2), x4), x16);
		sbox_calc = r ^ 8'h63;
	endfunction

	typedef byte_t sbox_tab_t [256];

	function automatic sbox_tab_t sbox_build();
		sbox_tab_t t;
		for (int i = 0; i < 256; i++) t[i] = sbox_calc(i[7:0]);
		sbox_build = t;
	endfunction

	localparam sbox_tab_t SboxTab = sbox_build();

	function automatic byte_t sbox(input byte_t x);
		sbox = SboxTab[x];
	endfunction

	typedef byte_t rcon_tab_t [10];
	localparam rcon_tab_t RconTab = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10,
		8'h20, 8'h40, 8'h80, 8'h1B, 8'h36};

	// Byte i of a block, byte 0 at the top
	function automatic byte_t blk_byte(input block_t b, input int i);
		blk_byte = b[127 - 8 * i -: 8];
	endfunction
endpackage

@@ hw/rtl/reduced_round_spn_block_encrypt.sv @@
// Top level: input key add, then a chain of round cells, one per round.
// Depends on rrspn_pkg and rrspn_cell.
//
//  channel  | handshake      | payload
//  request  | start / busy   | key_high key_low plain_high plain_low
//  result   | done (strobe)  | cipher_high cipher_low
//
// One request accepted every cycle; busy is always low.
// Each request passes through the initial key add register,
// then one register per round cell in the chain.
// Reset clears the valid bits of the chain; payload is not reset.
// The receiver cannot stall: each result shows for one cycle with done.
`timescale 1ns / 1ps
module reduced_round_spn_block_encrypt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [63:0] key_high,
	input  logic [63:0] key_low,
	input  logic [63:0] plain_high,
	input  logic [63:0] plain_low,
	output logic        done,
	output logic [63:0] cipher_high,
	output logic [63:0] cipher_low
);
	import rrspn_pkg::*;

	logic   vld [NumRounds + 1];
	block_t key [NumRounds + 1];
	block_t st  [NumRounds + 1];
	logic   valid_q;
	block_t key_q;
	block_t state_q;

	assign busy = 1'b0;

	// Register the request with the initial key add
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_q <= 1'b0;
		else valid_q <= start;
	end

	always_ff @(posedge clk) begin
		key_q <= {key_high, key_low};
		state_q <= {plain_high, plain_low} ^ {key_high, key_low};
	end

	assign vld[0] = valid_q;
	assign key[0] = key_q;
	assign st[0] = state_q;

	// Chain of round cells
	for (genvar g = 0; g < NumRounds; g++) begin : g_round
		rrspn_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.valid_in  (vld[g]),
			.key_in    (key[g]),
			.state_in  (st[g]),
			.rcon      (RconTab[g % 10]),
			.last      (g == NumRounds - 1),
			.valid_out (vld[g + 1]),
			.key_out   (key[g + 1]),
			.state_out (st[g + 1])
		);
	end

	assign done = vld[NumRounds];
	assign cipher_high = st[NumRounds][127:64];
	assign cipher_low = st[NumRounds][63:0];

`ifndef NO_ASSERTIONS
	a_first: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> valid_q) else $error("request not captured");
	a_chain: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |=> vld[1]) else $error("first cell lost a request");
	a_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!vld[NumRounds - 1] |=> !done) else $error("result without request");
`endif
endmodule

@@ hw/rtl/rrspn_cell.sv @@
// One round cell: round-key expansion and one cipher round, registered.
// Depends on rrspn_pkg.
`timescale 1ns / 1ps
module rrspn_cell (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  valid_in,
	input  rrspn_pkg::block_t     key_in,
	input  rrspn_pkg::block_t     state_in,
	input  rrspn_pkg::byte_t      rcon,
	input  logic                  last,
	output logic                  valid_out,
	output rrspn_pkg::block_t     key_out,
	output rrspn_pkg::block_t     state_out
);
	import rrspn_pkg::*;

	block_t nkey;
	block_t sr;
	block_t mx;
	block_t nstate;
	block_t key_s1;
	block_t state_s1;
	logic   valid_s1;

	// Expand the next round key from the previous one
	always_comb begin
		byte_t t0, t1, t2, t3;
		logic [31:0] w0, w1, w2, w3;
		t0 = sbox(blk_byte(key_in, 13)) ^ rcon;
		t1 = sbox(blk_byte(key_in, 14));
		t2 = sbox(blk_byte(key_in, 15));
		t3 = sbox(blk_byte(key_in, 12));
		w0 = key_in[127:96] ^ {t0, t1, t2, t3};
		w1 = key_in[95:64] ^ w0;
		w2 = key_in[63:32] ^ w1;
		w3 = key_in[31:0] ^ w2;
		nkey = {w0, w1, w2, w3};
	end

	// Substitute and shift rows
	always_comb begin
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++)
				sr[127 - 8 * (4 * c + r) -: 8] =
					sbox(blk_byte(state_in, 4 * ((c + r) % 4) + r));
	end

	// Mix columns
	always_comb begin
		byte_t a0, a1, a2, a3;
		for (int c = 0; c < 4; c++) begin
			a0 = blk_byte(sr, 4 * c);
			a1 = blk_byte(sr, 4 * c + 1);
			a2 = blk_byte(sr, 4 * c + 2);
			a3 = blk_byte(sr, 4 * c + 3);
			mx[127 - 32 * c -: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
			mx[119 - 32 * c -: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
			mx[111 - 32 * c -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
			mx[103 - 32 * c -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
		end
	end

	assign nstate = (last ? sr : mx) ^ nkey;

	// Advance valid; payload registers need no reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s1 <= 1'b0;
		else valid_s1 <= valid_in;
	end

	always_ff @(posedge clk) begin
		key_s1 <= nkey;
		state_s1 <= nstate;
	end

	assign valid_out = valid_s1;
	assign key_out = key_s1;
	assign state_out = state_s1;
endmodule
